>>> rtl/core/afl_pkg.sv
// Shared types, constants and the step program of the AMR refinement flagger.
package afl_pkg;

  // Field widths are fixed by the item format.
  localparam int unsigned VALUE_WIDTH   = 32;
  localparam int unsigned COUNT_WIDTH   = 32;
  localparam int unsigned DEF_FRAC_BITS = 16;

  // Arithmetic limbs of the shared multiply-accumulate unit.
  localparam int unsigned LIMB_W     = 32;
  localparam int unsigned MAC_W      = 2 * LIMB_W;
  localparam int unsigned ACC_LIMBS  = 6;
  localparam int unsigned LIMB_IDX_W = $clog2(ACC_LIMBS);

  // Pi rounded to 30 fraction bits.
  localparam logic [LIMB_W-1:0] PI_Q30  = 32'hC90F_DAA2;
  localparam int unsigned       PI_FRAC = 30;

  // Configuration port.
  localparam int unsigned APB_ADDR_W = 5;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned REG_IDX_W  = 3;
  localparam int unsigned MASK_W     = 4;

  localparam logic [REG_IDX_W-1:0] REG_ENABLE_MASK = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_MASS_LIMIT  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_GRAD_LIMIT  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_PART_LIMIT  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_HYSTERESIS  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_JEANS_CELLS = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_GRAVITY     = 3'd6;

  localparam logic [VALUE_WIDTH-1:0] HYSTERESIS_RST  = 32'd32768;
  localparam logic [VALUE_WIDTH-1:0] JEANS_CELLS_RST = 32'd262144;
  localparam logic [VALUE_WIDTH-1:0] GRAVITY_RST     = 32'd65536;

  // Bit positions of the four tests in the enable mask and flag vectors.
  localparam int unsigned TEST_MASS  = 0;
  localparam int unsigned TEST_GRAD  = 1;
  localparam int unsigned TEST_PART  = 2;
  localparam int unsigned TEST_JEANS = 3;

  // Decision codes.
  localparam logic [1:0] DEC_KEEP     = 2'd0;
  localparam logic [1:0] DEC_REFINE   = 2'd1;
  localparam logic [1:0] DEC_DEREFINE = 2'd2;

  // Step program.
  localparam int unsigned PC_W    = 5;
  localparam logic [PC_W-1:0] LAST_PC = 5'd28;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] density;
    logic [VALUE_WIDTH-1:0] gradient;
    logic [COUNT_WIDTH-1:0] particles;
    logic [VALUE_WIDTH-1:0] sound_speed;
    logic [VALUE_WIDTH-1:0] cell_width;
    logic                   last_cell;
  } in_item_t;

  typedef struct packed {
    logic [1:0] cell_verdict;
    logic [1:0] patch_decision;
    logic       patch_done;
  } out_item_t;

  typedef struct packed {
    logic [MASK_W-1:0]      enable_mask;
    logic [VALUE_WIDTH-1:0] mass_limit;
    logic [VALUE_WIDTH-1:0] gradient_limit;
    logic [COUNT_WIDTH-1:0] particle_limit;
    logic [VALUE_WIDTH-1:0] hysteresis;
    logic [VALUE_WIDTH-1:0] jeans_cells;
    logic [VALUE_WIDTH-1:0] gravity_constant;
  } cfg_t;

  typedef enum logic [1:0] {
    OP_NOP,
    OP_LOAD,
    OP_MUL,
    OP_CMP
  } op_e;

  typedef enum logic [3:0] {
    SRC_D,
    SRC_G,
    SRC_N,
    SRC_C,
    SRC_W,
    SRC_M,
    SRC_GL,
    SRC_PL,
    SRC_H,
    SRC_J,
    SRC_K,
    SRC_PI
  } src_e;

  typedef enum logic [2:0] {
    CMP_MASS_REF,
    CMP_MASS_VETO,
    CMP_GRAD_REF,
    CMP_GRAD_VETO,
    CMP_PART_REF,
    CMP_PART_VETO,
    CMP_JEANS_REF,
    CMP_JEANS_VETO
  } cmp_e;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_RUN,
    SEQ_DONE
  } seq_state_e;

  typedef struct packed {
    op_e                   op;
    src_e                  src;
    cmp_e                  kind;
    logic                  save;
    logic [LIMB_IDX_W-1:0] nlimb;
    logic                  last;
  } ustep_t;

  typedef struct packed {
    op_e                   op;
    src_e                  src;
    cmp_e                  kind;
    logic                  save;
    logic [LIMB_IDX_W-1:0] limb;
    logic                  limb_end;
  } dp_ctrl_t;

  typedef struct packed {
    logic [MASK_W-1:0] refine;
    logic [MASK_W-1:0] veto;
  } flags_t;

  function automatic ustep_t step_load(input src_e src, input logic save);
    ustep_t s;
    s = '{op: OP_LOAD, src: src, kind: CMP_MASS_REF, save: save, nlimb: '0, last: 1'b0};
    return s;
  endfunction

  function automatic ustep_t step_mul(input src_e src, input logic [LIMB_IDX_W-1:0] nlimb);
    ustep_t s;
    s = '{op: OP_MUL, src: src, kind: CMP_MASS_REF, save: 1'b0, nlimb: nlimb, last: 1'b0};
    return s;
  endfunction

  function automatic ustep_t step_cmp(input cmp_e kind, input logic save, input logic last);
    ustep_t s;
    s = '{op: OP_CMP, src: SRC_D, kind: kind, save: save, nlimb: '0, last: last};
    return s;
  endfunction

  // Each multiply step runs over as many limbs as the accumulator holds at that point.
  function automatic ustep_t afl_ucode(input logic [PC_W-1:0] pc);
    ustep_t s;
    case (pc)
      5'd0:    s = step_load(SRC_D, 1'b0);
      5'd1:    s = step_mul(SRC_W, 3'd1);
      5'd2:    s = step_mul(SRC_W, 3'd2);
      5'd3:    s = step_mul(SRC_W, 3'd3);
      5'd4:    s = step_cmp(CMP_MASS_REF, 1'b1, 1'b0);
      5'd5:    s = step_load(SRC_M, 1'b0);
      5'd6:    s = step_mul(SRC_H, 3'd1);
      5'd7:    s = step_cmp(CMP_MASS_VETO, 1'b0, 1'b0);
      5'd8:    s = step_load(SRC_GL, 1'b0);
      5'd9:    s = step_mul(SRC_H, 3'd1);
      5'd10:   s = step_cmp(CMP_GRAD_VETO, 1'b0, 1'b0);
      5'd11:   s = step_cmp(CMP_GRAD_REF, 1'b0, 1'b0);
      5'd12:   s = step_load(SRC_PL, 1'b0);
      5'd13:   s = step_mul(SRC_H, 3'd1);
      5'd14:   s = step_cmp(CMP_PART_VETO, 1'b0, 1'b0);
      5'd15:   s = step_cmp(CMP_PART_REF, 1'b0, 1'b0);
      5'd16:   s = step_load(SRC_J, 1'b0);
      5'd17:   s = step_mul(SRC_J, 3'd1);
      5'd18:   s = step_mul(SRC_K, 3'd2);
      5'd19:   s = step_mul(SRC_D, 3'd3);
      5'd20:   s = step_mul(SRC_W, 3'd4);
      5'd21:   s = step_mul(SRC_W, 3'd5);
      5'd22:   s = step_load(SRC_C, 1'b1);
      5'd23:   s = step_mul(SRC_C, 3'd1);
      5'd24:   s = step_mul(SRC_PI, 3'd2);
      5'd25:   s = step_cmp(CMP_JEANS_REF, 1'b0, 1'b0);
      5'd26:   s = step_mul(SRC_H, 3'd3);
      5'd27:   s = step_mul(SRC_H, 3'd4);
      5'd28:   s = step_cmp(CMP_JEANS_VETO, 1'b0, 1'b1);
      default: s = step_cmp(CMP_JEANS_VETO, 1'b0, 1'b1);
    endcase
    return s;
  endfunction

endpackage

>>> rtl/core/afl_regs.sv
// Configuration register file of the AMR refinement flagger behind an APB-style port.
module afl_regs import afl_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg_o
);

  cfg_t                 cfg_q, cfg_d;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        REG_ENABLE_MASK: cfg_d.enable_mask      = pwdata[MASK_W-1:0];
        REG_MASS_LIMIT:  cfg_d.mass_limit       = pwdata[VALUE_WIDTH-1:0];
        REG_GRAD_LIMIT:  cfg_d.gradient_limit   = pwdata[VALUE_WIDTH-1:0];
        REG_PART_LIMIT:  cfg_d.particle_limit   = pwdata[COUNT_WIDTH-1:0];
        REG_HYSTERESIS:  cfg_d.hysteresis       = pwdata[VALUE_WIDTH-1:0];
        REG_JEANS_CELLS: cfg_d.jeans_cells      = pwdata[VALUE_WIDTH-1:0];
        REG_GRAVITY:     cfg_d.gravity_constant = pwdata[VALUE_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ENABLE_MASK: prdata = APB_DATA_W'(cfg_q.enable_mask);
      REG_MASS_LIMIT:  prdata = APB_DATA_W'(cfg_q.mass_limit);
      REG_GRAD_LIMIT:  prdata = APB_DATA_W'(cfg_q.gradient_limit);
      REG_PART_LIMIT:  prdata = APB_DATA_W'(cfg_q.particle_limit);
      REG_HYSTERESIS:  prdata = APB_DATA_W'(cfg_q.hysteresis);
      REG_JEANS_CELLS: prdata = APB_DATA_W'(cfg_q.jeans_cells);
      REG_GRAVITY:     prdata = APB_DATA_W'(cfg_q.gravity_constant);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable_mask      <= '0;
      cfg_q.mass_limit       <= '0;
      cfg_q.gradient_limit   <= '0;
      cfg_q.particle_limit   <= '0;
      cfg_q.hysteresis       <= HYSTERESIS_RST;
      cfg_q.jeans_cells      <= JEANS_CELLS_RST;
      cfg_q.gravity_constant <= GRAVITY_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

>>> rtl/core/afl_seq.sv
// Step sequencer that walks the flagger's program and the limbs of each multiply.
module afl_seq import afl_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  logic     out_free_i,
  output logic     idle_o,
  output logic     result_load_o,
  output dp_ctrl_t ctrl_o
);

  seq_state_e            state_q, state_d;
  logic [PC_W-1:0]       pc_q, pc_d;
  logic [LIMB_IDX_W-1:0] limb_q, limb_d;
  ustep_t                step;
  logic                  limb_end;

  assign step     = afl_ucode(pc_q);
  assign limb_end = (limb_q == LIMB_IDX_W'(step.nlimb - 3'd1));

  // Next state.
  always_comb begin
    state_d = state_q;
    pc_d    = pc_q;
    limb_d  = limb_q;
    case (state_q)
      SEQ_IDLE: begin
        if (start_i) begin
          state_d = SEQ_RUN;
          pc_d    = '0;
          limb_d  = '0;
        end
      end
      SEQ_RUN: begin
        if (step.op == OP_MUL && !limb_end) begin
          limb_d = limb_q + LIMB_IDX_W'(1);
        end else begin
          limb_d = '0;
          pc_d   = pc_q + PC_W'(1);
          if (step.last) begin
            state_d = SEQ_DONE;
          end
        end
      end
      SEQ_DONE: begin
        if (out_free_i) begin
          state_d = SEQ_IDLE;
        end
      end
      default: state_d = SEQ_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    idle_o        = 1'b0;
    result_load_o = 1'b0;
    ctrl_o        = '{op: OP_NOP, src: SRC_D, kind: CMP_MASS_REF, save: 1'b0,
                      limb: '0, limb_end: 1'b0};
    case (state_q)
      SEQ_IDLE: idle_o = 1'b1;
      SEQ_RUN: begin
        ctrl_o = '{op: step.op, src: step.src, kind: step.kind, save: step.save,
                   limb: limb_q, limb_end: limb_end};
      end
      SEQ_DONE: result_load_o = out_free_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SEQ_IDLE;
      pc_q    <= '0;
      limb_q  <= '0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      limb_q  <= limb_d;
    end
  end

  a_pc_in_program: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SEQ_RUN) |-> (pc_q <= LAST_PC))
    else $error("step counter ran past the end of the program");

  a_limb_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SEQ_RUN && step.op == OP_MUL) |-> (limb_q < step.nlimb))
    else $error("limb counter ran past the accumulator length");

  a_done_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SEQ_RUN && step.last) |=> (state_q == SEQ_DONE))
    else $error("sequencer did not finish after the last step");

endmodule

>>> rtl/core/afl_datapath.sv
// Limb-serial multiply-accumulate unit, product store and shared wide comparator.
module afl_datapath import afl_pkg::*; #(
  parameter int unsigned FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic     clk_i,
  input  dp_ctrl_t ctrl_i,
  input  cfg_t     cfg_i,
  input  in_item_t item_i,
  output flags_t   flags_o
);

  localparam int unsigned AccW   = ACC_LIMBS * LIMB_W;
  localparam int unsigned WRhs   = AccW + PI_FRAC;
  localparam int unsigned WLr    = 3 * LIMB_W + 4 * FRAC_BITS;
  localparam int unsigned WLd    = 5 * LIMB_W + 2 * FRAC_BITS;
  localparam int unsigned WMax1  = (WRhs > WLr) ? WRhs : WLr;
  localparam int unsigned CmpW   = (WMax1 > WLd) ? WMax1 : WLd;
  localparam int unsigned ShF1   = FRAC_BITS;
  localparam int unsigned ShF2   = 2 * FRAC_BITS;
  localparam int unsigned ShF3   = 3 * FRAC_BITS;
  localparam int unsigned ShF4   = 4 * FRAC_BITS;

  logic [ACC_LIMBS-1:0][LIMB_W-1:0] acc_q, acc_d, save_q, save_d;
  logic [LIMB_W-1:0]                carry_q, carry_d;
  logic [LIMB_W-1:0]                oper, acc_limb, carry_in;
  logic [MAC_W-1:0]                 mac;
  logic [LIMB_IDX_W-1:0]            limb_nxt;
  logic [CmpW-1:0]                  acc_x, save_x, cmp_a, cmp_b;
  logic                             gt;
  flags_t                           flags_q, flags_d;

  always_comb begin
    case (ctrl_i.src)
      SRC_D:   oper = item_i.density;
      SRC_G:   oper = item_i.gradient;
      SRC_N:   oper = item_i.particles;
      SRC_C:   oper = item_i.sound_speed;
      SRC_W:   oper = item_i.cell_width;
      SRC_M:   oper = cfg_i.mass_limit;
      SRC_GL:  oper = cfg_i.gradient_limit;
      SRC_PL:  oper = cfg_i.particle_limit;
      SRC_H:   oper = cfg_i.hysteresis;
      SRC_J:   oper = cfg_i.jeans_cells;
      SRC_K:   oper = cfg_i.gravity_constant;
      SRC_PI:  oper = PI_Q30;
      default: oper = '0;
    endcase
  end

  // One 32x32 product plus the carry of the previous limb per cycle.
  assign acc_limb = acc_q[ctrl_i.limb];
  assign carry_in = (ctrl_i.limb == '0) ? '0 : carry_q;
  assign mac      = MAC_W'(acc_limb) * MAC_W'(oper) + MAC_W'(carry_in);
  assign limb_nxt = ctrl_i.limb + LIMB_IDX_W'(1);

  always_comb begin
    acc_d   = acc_q;
    save_d  = save_q;
    carry_d = carry_q;
    case (ctrl_i.op)
      OP_LOAD: begin
        acc_d    = '0;
        acc_d[0] = oper;
        if (ctrl_i.save) begin
          save_d = acc_q;
        end
      end
      OP_MUL: begin
        acc_d[ctrl_i.limb] = mac[LIMB_W-1:0];
        carry_d            = mac[MAC_W-1:LIMB_W];
        if (ctrl_i.limb_end && ctrl_i.limb != LIMB_IDX_W'(ACC_LIMBS - 1)) begin
          acc_d[limb_nxt] = mac[MAC_W-1:LIMB_W];
        end
      end
      OP_CMP: begin
        if (ctrl_i.save) begin
          save_d = acc_q;
        end
      end
      default: ;
    endcase
  end

  // Operands are aligned by constant shifts so every test is an exact integer compare.
  assign acc_x  = CmpW'(acc_q);
  assign save_x = CmpW'(save_q);

  always_comb begin
    case (ctrl_i.kind)
      CMP_MASS_REF: begin
        cmp_a = acc_x;
        cmp_b = CmpW'(cfg_i.mass_limit) << ShF3;
      end
      CMP_MASS_VETO: begin
        cmp_a = save_x;
        cmp_b = acc_x << ShF2;
      end
      CMP_GRAD_REF: begin
        cmp_a = CmpW'(item_i.gradient);
        cmp_b = CmpW'(cfg_i.gradient_limit);
      end
      CMP_GRAD_VETO: begin
        cmp_a = CmpW'(item_i.gradient) << ShF1;
        cmp_b = acc_x;
      end
      CMP_PART_REF: begin
        cmp_a = CmpW'(item_i.particles);
        cmp_b = CmpW'(cfg_i.particle_limit);
      end
      CMP_PART_VETO: begin
        cmp_a = CmpW'(item_i.particles) << ShF1;
        cmp_b = acc_x;
      end
      CMP_JEANS_REF: begin
        cmp_a = save_x << PI_FRAC;
        cmp_b = acc_x << ShF4;
      end
      CMP_JEANS_VETO: begin
        cmp_a = save_x << PI_FRAC;
        cmp_b = acc_x << ShF2;
      end
      default: begin
        cmp_a = '0;
        cmp_b = '0;
      end
    endcase
  end

  assign gt = (cmp_a > cmp_b);

  always_comb begin
    flags_d = flags_q;
    if (ctrl_i.op == OP_CMP) begin
      case (ctrl_i.kind)
        CMP_MASS_REF:   flags_d.refine[TEST_MASS]  = gt;
        CMP_MASS_VETO:  flags_d.veto[TEST_MASS]    = gt;
        CMP_GRAD_REF:   flags_d.refine[TEST_GRAD]  = gt;
        CMP_GRAD_VETO:  flags_d.veto[TEST_GRAD]    = gt;
        CMP_PART_REF:   flags_d.refine[TEST_PART]  = gt;
        CMP_PART_VETO:  flags_d.veto[TEST_PART]    = gt;
        CMP_JEANS_REF:  flags_d.refine[TEST_JEANS] = gt;
        CMP_JEANS_VETO: flags_d.veto[TEST_JEANS]   = gt;
        default: ;
      endcase
    end
  end

  assign flags_o = flags_q;

  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    save_q  <= save_d;
    carry_q <= carry_d;
    flags_q <= flags_d;
  end

endmodule

>>> rtl/core/amr_refinement_flagger.sv
// Top level of the AMR refinement flagger: ports, item capture, decision and patch state.
//
// Each input item carries the metrics of one mesh cell and yields exactly one result item
// with a keep, refine or derefine decision for that cell; the result of the cell marked
// last_cell also carries the decision for the whole patch (refine if any cell refined,
// derefine if every cell derefined, otherwise keep) and sets patch_done. Up to four tests
// are enabled through enable_mask: cell mass, gradient, particle count and the Jeans length
// criterion, each of which may request a refine and may veto a derefine with the band
// widened by the hysteresis factor. All real-valued quantities are unsigned fixed point
// with FRAC_BITS fraction bits, and every test is an exact comparison of wide integer
// products, so no rounding takes place except in the built-in constant pi. The arithmetic
// runs on a single 32x32 multiply-accumulate unit that works through a fixed program one
// 32-bit limb per cycle, followed by one shared wide comparator. A new item is accepted
// once the block is idle again, after the program and the hand-over of the result to the output
// register, which waits until that register is free. The output register lets the next
// item be accepted while a finished result still waits on out_ready_i. The user writes
// configuration through the APB-style port only while the block is idle; the block itself
// does not enforce this. pready is always high and register i lies at byte address 4*i.
module amr_refinement_flagger import afl_pkg::*; #(
  parameter int unsigned FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration port.
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  // Cell items in.
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_item_t              in_item_i,
  // Result items out.
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_item_t             out_item_o
);

  cfg_t      cfg;
  dp_ctrl_t  ctrl;
  flags_t    flags;
  in_item_t  item_q;
  out_item_t out_item_q, out_item_d;
  logic      out_valid_q, out_valid_d;
  logic      any_refine_q, any_refine_d;
  logic      all_derefine_q, all_derefine_d;
  logic      in_acc, idle, result_load, out_free;
  logic      jeans_ok, refine, veto;
  logic      any_n, all_n;
  logic [MASK_W-1:0] en_eff;
  logic [1:0]        cell_dec;

  afl_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign in_ready_o = idle;
  assign in_acc     = in_valid_i & idle;
  assign out_free   = ~out_valid_q | out_ready_i;

  afl_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (in_acc),
    .out_free_i    (out_free),
    .idle_o        (idle),
    .result_load_o (result_load),
    .ctrl_o        (ctrl)
  );

  afl_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk_i   (clk_i),
    .ctrl_i  (ctrl),
    .cfg_i   (cfg),
    .item_i  (item_q),
    .flags_o (flags)
  );

  // The cell's metrics are held for the whole program.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q <= in_item_i;
    end
  end

  // The Jeans test only applies to a cell with sound speed, density and a gravitational
  // constant that are all nonzero. A zero cell width makes its right-hand side zero, so it
  // then neither refines nor vetoes without any special handling.
  assign jeans_ok = cfg.enable_mask[TEST_JEANS] & (item_q.sound_speed != '0) &
                    (item_q.density != '0) & (cfg.gravity_constant != '0);

  always_comb begin
    en_eff             = cfg.enable_mask;
    en_eff[TEST_JEANS] = jeans_ok;
  end

  assign refine = |(en_eff & flags.refine);
  assign veto   = |(en_eff & flags.veto);

  always_comb begin
    if (refine) begin
      cell_dec = DEC_REFINE;
    end else if (!veto) begin
      cell_dec = DEC_DEREFINE;
    end else begin
      cell_dec = DEC_KEEP;
    end
  end

  // Patch summary including the current cell.
  assign any_n = any_refine_q | (cell_dec == DEC_REFINE);
  assign all_n = all_derefine_q & (cell_dec == DEC_DEREFINE);

  always_comb begin
    out_item_d     = out_item_q;
    out_valid_d    = out_valid_q;
    any_refine_d   = any_refine_q;
    all_derefine_d = all_derefine_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (result_load) begin
      out_valid_d             = 1'b1;
      out_item_d.cell_verdict = cell_dec;
      if (item_q.last_cell) begin
        // The last cell closes the patch and the summary starts over.
        if (any_n) begin
          out_item_d.patch_decision = DEC_REFINE;
        end else if (all_n) begin
          out_item_d.patch_decision = DEC_DEREFINE;
        end else begin
          out_item_d.patch_decision = DEC_KEEP;
        end
        out_item_d.patch_done = 1'b1;
        any_refine_d          = 1'b0;
        all_derefine_d        = 1'b1;
      end else begin
        out_item_d.patch_decision = DEC_KEEP;
        out_item_d.patch_done     = 1'b0;
        any_refine_d              = any_n;
        all_derefine_d            = all_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q    <= 1'b0;
      any_refine_q   <= 1'b0;
      all_derefine_q <= 1'b1;
    end else begin
      out_valid_q    <= out_valid_d;
      any_refine_q   <= any_refine_d;
      all_derefine_q <= all_derefine_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("block took an item while the previous one was still at work");

  a_open_patch_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_item_o.patch_done) |-> (out_item_o.patch_decision == DEC_KEEP))
    else $error("patch decision given on a cell that does not close the patch");

  a_refine_propagates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.patch_done && out_item_o.cell_verdict == DEC_REFINE)
      |-> (out_item_o.patch_decision == DEC_REFINE))
    else $error("refined last cell did not refine its patch");

endmodule
